// ----- src/mvfs_pkg.sv -----
// Package for the MPEG video frame splitter: result record, start codes, constants.
// No dependencies.
package mvfs_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CODE_PICTURE  = 8'h00;
  localparam logic [7:0] CODE_USERDATA = 8'hB2;
  localparam logic [7:0] CODE_SEQUENCE = 8'hB3;
  localparam logic [7:0] CODE_EXTEN    = 8'hB5;
  localparam logic [7:0] CODE_GOP      = 8'hB8;
  localparam logic [3:0] EXT_ID_SEQ    = 4'h1;
  localparam logic [2:0] PIC_TYPE_I    = 3'h1;

  localparam logic [1:0] VK_UNKNOWN = 2'd0;
  localparam logic [1:0] VK_MPEG1   = 2'd1;
  localparam logic [1:0] VK_MPEG2   = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] frame_offset;
    logic [31:0] frame_size;
    logic        keyframe;
    logic        header_found;
    logic [11:0] pic_width;
    logic [11:0] pic_height;
    logic [3:0]  aspect_code;
    logic [3:0]  rate_code;
    logic [17:0] bitrate_value;
    logic [1:0]  video_kind;
    logic        last_result;
  } result_t;

  // one parsed byte: up to three results, in order
  typedef struct packed {
    logic [2:0] valid;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } group_t;

endpackage

// ----- src/mpeg_video_frame_splitter_unit.sv -----
// MPEG-1/2 video frame splitter, top level. Depends on mvfs_pkg, mvfs_parser,
// mvfs_queue, mvfs_serializer.
// Throughput: one byte per cycle while the queue is not full; each byte is parsed
// in the cycle it is accepted. A byte's first result goes through a queue write,
// then an output register load. A byte with n results holds the queue head for n loads.
// Reset: synchronous active-low rst_n clears parser state, queue and output valid.
module mpeg_video_frame_splitter_unit import mvfs_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // frame_offset[31:0], frame_size[63:32], keyframe[64],
                                   // header_found[65], pic_width[77:66], pic_height[89:78],
                                   // aspect_code[93:90], rate_code[97:94],
                                   // bitrate_value[115:98], video_kind[117:116], zeros
  output logic         out_tuser,  // kind
  output logic         out_tlast   // last_result
);

  logic    acc, grp_valid, q_full, q_empty, q_pop;
  group_t  grp, q_data;
  result_t res;

  // queue may stall the input; back part drains independently
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  mvfs_parser #(.OFFSET_BITS(OFFSET_BITS)) u_parser (
    .clk, .rst_n, .byte_valid(acc), .data_byte(in_tdata), .end_of_stream(in_tlast),
    .grp_valid, .grp
  );

  mvfs_queue u_queue (
    .clk, .rst_n, .wr_en(grp_valid), .wr_data(grp), .full(q_full), .empty(q_empty),
    .rd_en(q_pop), .rd_data(q_data)
  );

  mvfs_serializer u_ser (
    .clk, .rst_n, .q_empty, .q_data, .q_pop, .out_valid(out_tvalid), .out_data(res),
    .out_ready(out_tready)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;
  assign out_tdata = {2'b00, res.video_kind, res.bitrate_value, res.rate_code,
                      res.aspect_code, res.pic_height, res.pic_width, res.header_found,
                      res.keyframe, res.frame_size, res.frame_offset};

endmodule

// ----- src/mvfs_parser.sv -----
// Front part: start code scan, header capture, frame boundary tracking.
// Depends on mvfs_pkg. Emits one result group per byte that causes any result.
module mvfs_parser import mvfs_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       grp_valid,
  output group_t     grp
);

  typedef logic [OFFSET_BITS-1:0] pos_t;

  pos_t       pos_r, cur_start_r, pre_start_r;
  logic       cur_valid_r, pre_valid_r, cur_key_r, any_emit_r;
  logic [1:0] zero_run_r, pic_cnt_r;
  logic       code_pend_r, saw_seq_r, hdr_valid_r, ext_pend_r, mpeg2_r;
  logic [3:0] cap_cnt_r;
  logic [7:0] hdr_r [7];

  pos_t       pos_nxt, cur_start_nxt, pre_start_nxt;
  logic       cur_valid_nxt, pre_valid_nxt, cur_key_nxt, any_emit_nxt;
  logic [1:0] zero_run_nxt, pic_cnt_nxt;
  logic       code_pend_nxt, saw_seq_nxt, hdr_valid_nxt, ext_pend_nxt, mpeg2_nxt;
  logic [3:0] cap_cnt_nxt;
  group_t     grp_c;

  function automatic result_t frame_res(pos_t off, pos_t sz, logic key);
    result_t r;
    r = '0;
    r.frame_offset = 32'(off);
    r.frame_size   = 32'(sz);
    r.keyframe     = key;
    return r;
  endfunction

  always_comb begin
    pos_t     p, end_p, size;
    result_t  res [3];
    result_t  summ;
    logic [1:0] n;
    logic       is_prefix;
    pos_nxt = pos_r; cur_start_nxt = cur_start_r; pre_start_nxt = pre_start_r;
    cur_valid_nxt = cur_valid_r; pre_valid_nxt = pre_valid_r;
    cur_key_nxt = cur_key_r; any_emit_nxt = any_emit_r;
    zero_run_nxt = zero_run_r; pic_cnt_nxt = pic_cnt_r;
    code_pend_nxt = code_pend_r; saw_seq_nxt = saw_seq_r;
    hdr_valid_nxt = hdr_valid_r; ext_pend_nxt = ext_pend_r; mpeg2_nxt = mpeg2_r;
    cap_cnt_nxt = cap_cnt_r;
    res[0] = '0; res[1] = '0; res[2] = '0; summ = '0;
    n = 2'd0;
    p = pos_r - pos_t'(3);
    end_p = '0;
    size = pos_r + pos_t'(1);
    is_prefix = 1'b0;

    if (cap_cnt_r != 4'd0) begin
      if (cap_cnt_r == 4'd8) begin
        hdr_valid_nxt = 1'b1;
        cap_cnt_nxt   = 4'd0;
      end else begin
        cap_cnt_nxt = cap_cnt_r + 4'd1;
      end
    end
    if (ext_pend_r) begin
      ext_pend_nxt = 1'b0;
      if (data_byte[7:4] == EXT_ID_SEQ) mpeg2_nxt = 1'b1;
    end
    if (pic_cnt_r == 2'd1) pic_cnt_nxt = 2'd2;
    else if (pic_cnt_r == 2'd2) begin
      pic_cnt_nxt = 2'd0;
      cur_key_nxt = (data_byte[5:3] == PIC_TYPE_I);
    end

    if (code_pend_r) begin
      code_pend_nxt = 1'b0;
      zero_run_nxt  = (data_byte == 8'h00) ? 2'd1 : 2'd0;
      if (data_byte == CODE_SEQUENCE) begin
        saw_seq_nxt = 1'b1;
        if (!hdr_valid_nxt && cap_cnt_nxt == 4'd0) cap_cnt_nxt = 4'd1;
      end else if (data_byte == CODE_EXTEN && saw_seq_r) begin
        ext_pend_nxt = 1'b1;
      end
      is_prefix = (data_byte == CODE_USERDATA) || (data_byte == CODE_SEQUENCE) ||
                  (data_byte == CODE_EXTEN) || (data_byte == CODE_GOP);
      if (data_byte == CODE_PICTURE) begin
        end_p = pre_valid_r ? pre_start_r : p;
        if (cur_valid_r && end_p > cur_start_r) begin
          res[0] = frame_res(cur_start_r, end_p - cur_start_r, cur_key_r);
          n = 2'd1;
          any_emit_nxt = 1'b1;
        end
        cur_start_nxt = end_p;
        cur_valid_nxt = 1'b1;
        pre_valid_nxt = 1'b0;
        cur_key_nxt   = 1'b0;
        pic_cnt_nxt   = 2'd1;
      end else if (is_prefix && !pre_valid_r) begin
        pre_start_nxt = p;
        pre_valid_nxt = 1'b1;
      end
    end else if (data_byte == 8'h00) begin
      if (zero_run_r < 2'd2) zero_run_nxt = zero_run_r + 2'd1;
    end else if (data_byte == 8'h01 && zero_run_r == 2'd2) begin
      code_pend_nxt = 1'b1;
      zero_run_nxt  = 2'd0;
    end else begin
      zero_run_nxt = 2'd0;
    end

    pos_nxt = size;
    if (end_of_stream) begin
      if (cur_valid_nxt && cur_start_nxt < size) begin
        res[n] = frame_res(cur_start_nxt, size - cur_start_nxt, cur_key_nxt);
        n = n + 2'd1;
        any_emit_nxt = 1'b1;
      end
      if (!any_emit_nxt && size != '0) begin
        res[n] = frame_res('0, size, 1'b1);
        n = n + 2'd1;
      end
      summ.kind = 1'b1;
      summ.last_result = 1'b1;
      // final capture byte may arrive with end of stream
      if (hdr_valid_nxt) begin
        summ.header_found  = 1'b1;
        summ.pic_width     = {hdr_r[0], hdr_r[1][7:4]};
        summ.pic_height    = {hdr_r[1][3:0], hdr_r[2]};
        summ.aspect_code   = hdr_r[3][7:4];
        summ.rate_code     = hdr_r[3][3:0];
        summ.bitrate_value = {hdr_r[4], hdr_r[5], hdr_r[6][7:6]};
      end
      summ.video_kind = mpeg2_nxt ? VK_MPEG2 : (saw_seq_nxt ? VK_MPEG1 : VK_UNKNOWN);
      res[n] = summ;
      n = n + 2'd1;
    end else if (n != 2'd0) begin
      res[0].last_result = 1'b1;
    end

    grp_c.valid = (n == 2'd3) ? 3'b111 : (n == 2'd2) ? 3'b011 :
                  (n == 2'd1) ? 3'b001 : 3'b000;
    grp_c.r0 = res[0];
    grp_c.r1 = res[1];
    grp_c.r2 = res[2];
  end

  assign grp_valid = byte_valid && (grp_c.valid != 3'b000);
  assign grp       = grp_c;

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && end_of_stream)) begin
      pos_r <= '0; cur_start_r <= '0; pre_start_r <= '0;
      cur_valid_r <= 1'b0; pre_valid_r <= 1'b0; cur_key_r <= 1'b0;
      any_emit_r <= 1'b0; zero_run_r <= '0; pic_cnt_r <= '0;
      code_pend_r <= 1'b0; saw_seq_r <= 1'b0; hdr_valid_r <= 1'b0;
      ext_pend_r <= 1'b0; mpeg2_r <= 1'b0; cap_cnt_r <= '0;
    end else if (byte_valid) begin
      pos_r <= pos_nxt; cur_start_r <= cur_start_nxt; pre_start_r <= pre_start_nxt;
      cur_valid_r <= cur_valid_nxt; pre_valid_r <= pre_valid_nxt;
      cur_key_r <= cur_key_nxt; any_emit_r <= any_emit_nxt;
      zero_run_r <= zero_run_nxt; pic_cnt_r <= pic_cnt_nxt;
      code_pend_r <= code_pend_nxt; saw_seq_r <= saw_seq_nxt;
      hdr_valid_r <= hdr_valid_nxt; ext_pend_r <= ext_pend_nxt;
      mpeg2_r <= mpeg2_nxt; cap_cnt_r <= cap_cnt_nxt;
    end
  end

  // header bytes: gated by capture count; cleared by reset and at end of stream
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && end_of_stream)) begin
      for (int i = 0; i < 7; i++) hdr_r[i] <= 8'h00;
    end else if (byte_valid && cap_cnt_r >= 4'd1 && cap_cnt_r <= 4'd7) begin
      hdr_r[3'(cap_cnt_r - 4'd1)] <= data_byte;
    end
  end

endmodule

// ----- src/mvfs_queue.sv -----
// Short FIFO of result groups between parser and output serializer.
// Depends on mvfs_pkg.
module mvfs_queue import mvfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  group_t wr_data,
  output logic   full,
  output logic   empty,
  input  logic   rd_en,
  output group_t rd_data
);

  localparam int AW = $clog2(DEPTH);

  group_t        mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

// ----- src/mvfs_serializer.sv -----
// Back part: walks the results of one queued group into a registered output.
// Depends on mvfs_pkg.
module mvfs_serializer import mvfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  group_t  q_data,
  output logic    q_pop,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic [1:0] idx_r;
  logic       ovalid_r;
  result_t    odata_r;
  logic       load;
  logic       last_of_grp;
  result_t    cur;

  always_comb begin
    case (idx_r)
      2'd0:    cur = q_data.r0;
      2'd1:    cur = q_data.r1;
      default: cur = q_data.r2;
    endcase
    case (idx_r)
      2'd0:    last_of_grp = !q_data.valid[1];
      2'd1:    last_of_grp = !q_data.valid[2];
      default: last_of_grp = 1'b1;
    endcase
  end

  assign load      = !q_empty && (!ovalid_r || out_ready);
  assign q_pop     = load && last_of_grp;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (load) idx_r <= last_of_grp ? 2'd0 : idx_r + 2'd1;
      if (load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) odata_r <= cur;
  end

endmodule

// ----- src/mvfs_checker.sv -----
// Port-level checks for the frame splitter; bound to the top level.
// Depends on mpeg_video_frame_splitter_unit ports only.
module mvfs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("summary not marked last");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[64:0] == 65'd0)
    else $error("summary carries frame fields");

  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[119:65] == 55'd0)
    else $error("frame carries summary fields");

endmodule

bind mpeg_video_frame_splitter_unit mvfs_checker u_mvfs_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);

// ----- tb/mpeg_video_frame_splitter_unit_tb.sv -----
// Testbench for mpeg_video_frame_splitter_unit: directed byte table, then random streams.
// Depends on mvfs_pkg and the RTL top level; the scoreboard holds its own parser model.
module mpeg_video_frame_splitter_unit_tb import mvfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 380;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  mpeg_video_frame_splitter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- parser model
  logic [31:0] stream_pos;
  int          zero_cnt;
  logic        code_next;
  logic        seq_seen;
  int          hdr_cnt;
  logic [7:0]  hdr_buf [7];
  logic        hdr_done;
  logic        ext_next;
  logic        is_mpeg2;
  logic        frame_open;
  logic [31:0] frame_start;
  logic        lead_open;
  logic [31:0] lead_start;
  logic        frame_key;
  int          pic_cnt;
  logic        frame_sent;

  result_t     frames_due[$];   // predicted results, oldest first
  int          fail_cnt = 0;
  int          result_cnt = 0;
  int          stream_cnt = 0;
  int          byte_cnt = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;

  task automatic clear_parser();
    stream_pos = '0;
    zero_cnt = 0;
    code_next = 1'b0;
    seq_seen = 1'b0;
    hdr_cnt = 0;
    foreach (hdr_buf[i]) hdr_buf[i] = 8'h00;
    hdr_done = 1'b0;
    ext_next = 1'b0;
    is_mpeg2 = 1'b0;
    frame_open = 1'b0;
    frame_start = '0;
    lead_open = 1'b0;
    lead_start = '0;
    frame_key = 1'b0;
    pic_cnt = 0;
    frame_sent = 1'b0;
  endtask

  function automatic result_t frame_rec(logic [31:0] off, logic [31:0] sz, logic key);
    result_t r;
    r = '0;
    r.frame_offset = off;
    r.frame_size = sz;
    r.keyframe = key;
    return r;
  endfunction

  // Parse one accepted byte; queue the frame ranges / summary it causes.
  task automatic parse_byte(input logic [7:0] b, input logic eos, output result_t fin);
    result_t     r [3];
    int          n;
    logic [31:0] p;
    logic [31:0] stop;
    logic [31:0] sz;
    n = 0;
    fin = '0;
    if (hdr_cnt >= 1 && hdr_cnt <= 8) begin
      if (hdr_cnt <= 7) hdr_buf[hdr_cnt-1] = b;
      hdr_cnt++;
      if (hdr_cnt == 9) begin
        hdr_done = 1'b1;
        hdr_cnt = 0;
      end
    end
    if (ext_next) begin
      ext_next = 1'b0;
      if (b[7:4] == EXT_ID_SEQ) is_mpeg2 = 1'b1;
    end
    if (pic_cnt == 1) begin
      pic_cnt = 2;
    end else if (pic_cnt == 2) begin
      pic_cnt = 0;
      frame_key = (b[5:3] == PIC_TYPE_I);
    end

    if (code_next) begin
      code_next = 1'b0;
      p = stream_pos - 32'd3;   // offset of the first prefix zero
      if (b == CODE_SEQUENCE) begin
        seq_seen = 1'b1;
        if (!hdr_done && hdr_cnt == 0) hdr_cnt = 1;
      end else if (b == CODE_EXTEN && seq_seen) begin
        ext_next = 1'b1;
      end
      if (b == CODE_PICTURE) begin
        if (frame_open) begin
          stop = lead_open ? lead_start : p;
          if (stop > frame_start) begin
            r[n] = frame_rec(frame_start, stop - frame_start, frame_key);
            n++;
            frame_sent = 1'b1;
          end
        end
        frame_start = lead_open ? lead_start : p;
        frame_open = 1'b1;
        lead_open = 1'b0;
        frame_key = 1'b0;
        pic_cnt = 1;
      end else if ((b == CODE_USERDATA || b == CODE_SEQUENCE || b == CODE_EXTEN ||
                    b == CODE_GOP) && !lead_open) begin
        lead_start = p;
        lead_open = 1'b1;
      end
      zero_cnt = (b == 8'h00) ? 1 : 0;
    end else if (b == 8'h00) begin
      if (zero_cnt < 2) zero_cnt++;
    end else if (b == 8'h01 && zero_cnt >= 2) begin
      code_next = 1'b1;
      zero_cnt = 0;
    end else begin
      zero_cnt = 0;
    end

    if (eos) begin
      sz = stream_pos + 32'd1;
      if (frame_open && frame_start < sz) begin
        r[n] = frame_rec(frame_start, sz - frame_start, frame_key);
        n++;
        frame_sent = 1'b1;
      end
      if (!frame_sent && sz != 0) begin
        r[n] = frame_rec(32'd0, sz, 1'b1);   // whole stream as one keyframe
        n++;
      end
      r[n] = '0;
      r[n].kind = 1'b1;
      if (hdr_done) begin
        r[n].header_found = 1'b1;
        r[n].pic_width = {hdr_buf[0], hdr_buf[1][7:4]};
        r[n].pic_height = {hdr_buf[1][3:0], hdr_buf[2]};
        r[n].aspect_code = hdr_buf[3][7:4];
        r[n].rate_code = hdr_buf[3][3:0];
        r[n].bitrate_value = {hdr_buf[4], hdr_buf[5], hdr_buf[6][7:6]};
      end
      r[n].video_kind = is_mpeg2 ? VK_MPEG2 : (seq_seen ? VK_MPEG1 : VK_UNKNOWN);
      n++;
      clear_parser();
      stream_cnt++;
    end else begin
      stream_pos = stream_pos + 32'd1;
    end

    if (n > 0) begin
      r[n-1].last_result = 1'b1;
      fin = r[n-1];
    end
    for (int i = 0; i < n; i++) frames_due = {frames_due, r[i]};
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.frame_offset = out_tdata[31:0];
      got.frame_size = out_tdata[63:32];
      got.keyframe = out_tdata[64];
      got.header_found = out_tdata[65];
      got.pic_width = out_tdata[77:66];
      got.pic_height = out_tdata[89:78];
      got.aspect_code = out_tdata[93:90];
      got.rate_code = out_tdata[97:94];
      got.bitrate_value = out_tdata[115:98];
      got.video_kind = out_tdata[117:116];
      got.last_result = out_tlast;
      result_cnt++;
      if (frames_due.size() == 0) begin
        report("unexpected transaction", {31'd0, out_tuser}, 32'd0);
      end else begin
        want = frames_due.pop_front();
        if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
        if (got.frame_offset !== want.frame_offset)
          report("frame_offset", got.frame_offset, want.frame_offset);
        if (got.frame_size !== want.frame_size)
          report("frame_size", got.frame_size, want.frame_size);
        if (got.keyframe !== want.keyframe)
          report("keyframe", 32'(got.keyframe), 32'(want.keyframe));
        if (got.header_found !== want.header_found)
          report("header_found", 32'(got.header_found), 32'(want.header_found));
        if (got.pic_width !== want.pic_width)
          report("pic_width", 32'(got.pic_width), 32'(want.pic_width));
        if (got.pic_height !== want.pic_height)
          report("pic_height", 32'(got.pic_height), 32'(want.pic_height));
        if (got.aspect_code !== want.aspect_code)
          report("aspect_code", 32'(got.aspect_code), 32'(want.aspect_code));
        if (got.rate_code !== want.rate_code)
          report("rate_code", 32'(got.rate_code), 32'(want.rate_code));
        if (got.bitrate_value !== want.bitrate_value)
          report("bitrate_value", 32'(got.bitrate_value), 32'(want.bitrate_value));
        if (got.video_kind !== want.video_kind)
          report("video_kind", 32'(got.video_kind), 32'(want.video_kind));
        if (got.last_result !== want.last_result)
          report("last_result", 32'(got.last_result), 32'(want.last_result));
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // watchdog
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", frames_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Present one byte, hold it until the handshake completes, then predict.
  task automatic send_byte(input logic [7:0] b, input logic eos, output result_t fin);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    byte_cnt++;
    parse_byte(b, eos, fin);
  endtask

  function automatic logic [7:0] fill_byte();
    case ($urandom_range(5))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random stream: mostly start-code chunks with random payload, some pure noise.
  task automatic build_stream(ref logic [7:0] sb[$]);
    int   target;
    int   plen;
    logic [7:0] code;
    sb.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    if ($urandom_range(7) == 0) begin
      while (sb.size() < target) sb = {sb, fill_byte()};
      return;
    end
    while (sb.size() < target) begin
      if ($urandom_range(5) == 0) begin
        sb = {sb, fill_byte()};
        continue;
      end
      repeat ($urandom_range(2, 4)) sb = {sb, 8'h00};
      sb = {sb, 8'h01};
      case ($urandom_range(7))
        0, 1, 2: code = CODE_PICTURE;
        3:       code = CODE_SEQUENCE;
        4:       code = CODE_EXTEN;
        5:       code = CODE_GOP;
        6:       code = CODE_USERDATA;
        default: code = 8'($urandom);
      endcase
      sb = {sb, code};
      if (code == CODE_PICTURE) begin
        sb = {sb, 8'($urandom)};
        sb = {sb, {2'($urandom), 3'($urandom_range(0, 4)), 3'($urandom)}};
        plen = $urandom_range(0, 4);
      end else if (code == CODE_SEQUENCE) begin
        plen = 8;
      end else if (code == CODE_EXTEN) begin
        sb = {sb, {($urandom_range(1) ? EXT_ID_SEQ : 4'($urandom)), 4'($urandom)}};
        plen = $urandom_range(0, 3);
      end else begin
        plen = $urandom_range(0, 4);
      end
      repeat (plen) sb = {sb, (($urandom_range(2) == 0) ? fill_byte() : 8'($urandom))};
    end
    while (sb.size() > target) void'(sb.pop_back());
  endtask

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       known;   // final result typed in below
    result_t    fin;
  } stim_row_t;

  stim_row_t steps[$];

  task automatic add_row(input logic [7:0] b, input logic eos);
    stim_row_t s;
    s.b = b;
    s.eos = eos;
    s.known = 1'b0;
    s.fin = '0;
    steps = {steps, s};
  endtask

  initial begin
    result_t    fin;
    result_t    hdr_sum;
    logic [7:0] sb[$];
    logic [7:0] seq_rows [12];
    logic [7:0] pic_rows [11];
    int         sent;
    int         phase_cnt;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte stream: whole-stream keyframe then an empty summary
    add_row(8'hFF, 1'b1);
    steps[steps.size()-1].known = 1'b1;
    steps[steps.size()-1].fin = '0;
    steps[steps.size()-1].fin.kind = 1'b1;
    steps[steps.size()-1].fin.last_result = 1'b1;
    // sequence header 320x240, aspect 1, rate 3, max bit rate
    seq_rows = '{8'h00, 8'h00, 8'h01, CODE_SEQUENCE, 8'h14, 8'h00, 8'hF0, 8'h13,
                 8'hFF, 8'hFF, 8'hE0, 8'h00};
    foreach (seq_rows[i]) add_row(seq_rows[i], 1'b0);
    // extension with id 1 -> MPEG-2; then an intra picture
    pic_rows = '{8'h00, 8'h00, 8'h01, CODE_EXTEN, 8'h14, 8'h00, 8'h00, 8'h01,
                 CODE_PICTURE, 8'h00, 8'h08};
    foreach (pic_rows[i]) add_row(pic_rows[i], 1'b0);
    // bare prefix at stream end is ignored
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b1);
    hdr_sum = '0;
    hdr_sum.kind = 1'b1;
    hdr_sum.header_found = 1'b1;
    hdr_sum.pic_width = 12'd320;
    hdr_sum.pic_height = 12'd240;
    hdr_sum.aspect_code = 4'd1;
    hdr_sum.rate_code = 4'd3;
    hdr_sum.bitrate_value = 18'h3FFFF;
    hdr_sum.video_kind = VK_MPEG2;
    hdr_sum.last_result = 1'b1;
    steps[steps.size()-1].known = 1'b1;
    steps[steps.size()-1].fin = hdr_sum;

    foreach (steps[i]) begin
      send_byte(steps[i].b, steps[i].eos, fin);
      if (steps[i].known && fin !== steps[i].fin)
        report("directed final result", fin.frame_size, steps[i].fin.frame_size);
    end

    // random streams in three idling phases
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 17 : (ph == 1) ? 68 : 0;
      rcv_idle = (ph == 0) ? 68 : (ph == 1) ? 17 : 0;
      phase_cnt = 0;
      while (phase_cnt < RANDOM_BYTES / 3) begin
        build_stream(sb);
        foreach (sb[i]) send_byte(sb[i], i == sb.size() - 1, fin);
        phase_cnt += sb.size();
      end
      sent += phase_cnt;
    end
    in_tvalid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes (%0d random) in %0d streams, %0d results checked",
             byte_cnt, sent, stream_cnt, result_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mvfs_pkg.sv
src/mvfs_parser.sv
src/mvfs_queue.sv
src/mvfs_serializer.sv
src/mpeg_video_frame_splitter_unit.sv
src/mvfs_checker.sv
tb/mpeg_video_frame_splitter_unit_tb.sv
